/* rtl/hfva_pkg.sv */
// Package: shared types, constants and sine table for the flow vector accumulator.
package hfva_pkg;
    localparam int DETECTORS = 32;
    localparam int HARMONICS = 4;
    localparam int ENTRIES   = DETECTORS * HARMONICS;
    localparam int EW        = $clog2(ENTRIES);
    localparam int HW        = 2;
    localparam int DW        = 5;
    localparam int SUMW      = 48;
    localparam int WSW       = 40;
    localparam int ROWW      = 2 * SUMW + WSW;
    localparam int QDEPTH    = 2;

    localparam logic [1:0] OP_ANGLE = 2'd0;
    localparam logic [1:0] OP_XY    = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic signed [SUMW-1:0] SUM_MAX = {1'b0, {(SUMW-1){1'b1}}};
    localparam logic signed [SUMW-1:0] SUM_MIN = {1'b1, {(SUMW-1){1'b0}}};
    localparam logic [WSW-1:0]         WS_MAX  = {WSW{1'b1}};

    // Command handed from the front end to the back end.
    typedef struct packed {
        logic [1:0]        op;
        logic              in_range;
        logic [DW-1:0]     detector;
        logic [HW-1:0]     harmonic;
        logic [15:0]       angle;
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic [15:0]       weight;
        logic              negate;
    } cmd_t;

    // Quarter-wave sine table, Q1.15, 257 entries.
    function automatic logic [15:0] quarter_sine(input logic [8:0] i);
        logic [63:0] x, x2, t, s, r;
        x  = (64'(i) * 64'd1686629713) >> 8;
        x2 = (x * x) >> 30;
        t  = 64'd1073741824;
        t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd110);
        t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd72);
        t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd42);
        t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd20);
        t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd6);
        s = (x * t) >> 30;
        r = (s + 64'd16384) >> 15;
        return (r > 64'd32767) ? 16'd32767 : r[15:0];
    endfunction

    typedef logic [15:0] sine_rom_t [257];

    function automatic sine_rom_t build_rom();
        sine_rom_t rom;
        for (int i = 0; i < 257; i++) begin
            rom[i] = quarter_sine(9'(i));
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_rom();

    function automatic logic signed [15:0] sine_q15(input logic [15:0] phase);
        logic [15:0] mag;
        logic [8:0]  idx;
        idx = phase[14] ? (9'd256 - {1'b0, phase[13:6]}) : {1'b0, phase[13:6]};
        mag = SINE_ROM[idx];
        return phase[15] ? -$signed(mag) : $signed(mag);
    endfunction
endpackage

/* rtl/hfva_ram.sv */
// Generic single-port-write, registered-read RAM.
module hfva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/hfva_front.sv */
// Front end: accept requests, classify range, push into a short command queue.
module hfva_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_op,
    input  logic [4:0]              s_detector,
    input  logic [1:0]              s_harmonic,
    input  logic [15:0]             s_angle,
    input  logic signed [15:0]      s_x_pos,
    input  logic signed [15:0]      s_y_pos,
    input  logic [15:0]             s_weight,
    input  logic                    s_negate,
    output logic                    q_valid,
    input  logic                    q_ready,
    output hfva_pkg::cmd_t          q_cmd
);
    import hfva_pkg::*;

    cmd_t       slot_reg [QDEPTH];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cmd;
    logic       push, pop;

    always_comb begin
        cmd.op       = s_op;
        cmd.in_range = (32'(s_detector) < DETECTORS) && (32'(s_harmonic) < HARMONICS);
        if (s_op == OP_ANGLE) begin
            cmd.in_range = 32'(s_detector) < DETECTORS;
        end
        cmd.detector = s_detector;
        cmd.harmonic = s_harmonic;
        cmd.angle    = s_angle;
        cmd.x_pos    = s_x_pos;
        cmd.y_pos    = s_y_pos;
        cmd.weight   = s_weight;
        cmd.negate   = s_negate;
    end

    assign s_ready = cnt_reg != 2'(QDEPTH);
    assign push    = s_valid && s_ready;
    assign q_valid = cnt_reg != 2'd0;
    assign pop     = q_valid && q_ready;
    assign q_cmd   = slot_reg[rp_reg];
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= cmd;
        end
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_reg + 1'(push);
            rp_reg  <= rp_reg + 1'(pop);
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'(QDEPTH)) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'(QDEPTH) |-> !push) else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> cnt_reg != 2'd0) else $error("pop from empty queue");
endmodule

/* rtl/hfva_div.sv */
// Restoring divider: 48-bit signed over 40-bit unsigned, saturating Q1.15 quotient.
module hfva_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [hfva_pkg::SUMW-1:0] num,
    input  logic [hfva_pkg::WSW-1:0]   den,
    output logic                       done,
    output logic signed [15:0]         quot
);
    import hfva_pkg::*;

    localparam int CW = $clog2(SUMW + 1);

    logic [SUMW-1:0] q_reg, q_next;
    logic [WSW:0]    r_reg, r_next;
    logic [WSW-1:0]  d_reg;
    logic            neg_reg, busy_reg, done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [WSW+1:0]  trial;
    logic [SUMW-1:0] mag;

    assign mag   = num[SUMW-1] ? SUMW'(-num) : SUMW'(num);
    assign trial = {r_reg, q_reg[SUMW-1]} - {2'b0, d_reg};

    always_comb begin
        q_next = {q_reg[SUMW-2:0], 1'b0};
        r_next = {r_reg[WSW-1:0], q_reg[SUMW-1]};
        if (!trial[WSW+1]) begin
            r_next    = trial[WSW:0];
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= mag;
            r_reg   <= '0;
            d_reg   <= den;
            neg_reg <= num[SUMW-1];
        end else if (busy_reg) begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(SUMW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    always_comb begin
        if (neg_reg) begin
            quot = (q_reg > SUMW'(32768)) ? -16'sd32768 : -$signed(q_reg[15:0]);
        end else begin
            quot = (q_reg > SUMW'(32767)) ? 16'sd32767 : $signed(q_reg[15:0]);
        end
    end
endmodule

/* rtl/hfva_back.sv */
// Back end: sequencer for table updates, clear sweep and normalized reads.
module hfva_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  hfva_pkg::cmd_t          q_cmd,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [15:0]      m_qx_norm,
    output logic signed [15:0]      m_qy_norm,
    output logic [39:0]             m_weight_total,
    output logic                    m_valid_res
);
    import hfva_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_WR    = 3'd2;
    localparam logic [2:0] ST_CLR   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_WAIT  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]    st_reg;
    cmd_t          cmd_reg;
    logic [HW-1:0] k_reg;
    logic [EW:0]   clr_reg;

    logic [EW-1:0] addr, waddr;
    logic [ROWW-1:0] rdata, wdata;
    logic          we;
    logic signed [SUMW-1:0] xs, ys, nx, ny;
    logic [WSW-1:0] ws, nw;
    logic signed [SUMW-1:0] dx_reg, dy_reg;
    logic [WSW:0]  wsum;

    logic [HW-1:0] kh;
    logic [15:0]   ph;
    logic signed [15:0] cv, sv, mx, my;
    logic signed [16:0] sw;

    logic          dstart, dxdone;
    logic signed [15:0] qx, qy;
    logic          xdy;

    assign kh    = (cmd_reg.op == OP_ANGLE) ? k_reg : cmd_reg.harmonic;
    assign addr  = EW'(32'(cmd_reg.detector) * HARMONICS + 32'(kh));
    assign {xs, ys, ws} = rdata;

    always_comb begin
        ph = 16'(32'(cmd_reg.angle) * (32'(k_reg) + 1));
        cv = sine_q15(ph + 16'd16384);
        sv = sine_q15(ph);
        sw = (cmd_reg.negate && !kh[0]) ? -$signed({1'b0, cmd_reg.weight})
                                        : $signed({1'b0, cmd_reg.weight});
        mx = (cmd_reg.op == OP_ANGLE) ? cv : cmd_reg.x_pos;
        my = (cmd_reg.op == OP_ANGLE) ? sv : cmd_reg.y_pos;
    end

    function automatic logic signed [SUMW-1:0] sat_add(
        input logic signed [SUMW-1:0] a, input logic signed [SUMW-1:0] b);
        logic signed [SUMW:0] s;
        s = {a[SUMW-1], a} + {b[SUMW-1], b};
        if (s[SUMW] != s[SUMW-1]) begin
            return s[SUMW] ? SUM_MIN : SUM_MAX;
        end
        return s[SUMW-1:0];
    endfunction

    assign wsum = {1'b0, ws} + (WSW+1)'(cmd_reg.weight);
    assign nx   = sat_add(xs, dx_reg);
    assign ny   = sat_add(ys, dy_reg);
    assign nw   = wsum[WSW] ? WS_MAX : wsum[WSW-1:0];

    assign we    = (st_reg == ST_WR) || (st_reg == ST_CLR);
    assign waddr = (st_reg == ST_CLR) ? clr_reg[EW-1:0] : addr;
    assign wdata = (st_reg == ST_CLR) ? '0 : {nx, ny, nw};

    hfva_ram #(.WIDTH(ROWW), .DEPTH(ENTRIES)) u_ram (
        .aclk (aclk), .we (we), .waddr (waddr), .wdata (wdata),
        .raddr (addr), .rdata (rdata)
    );

    // Start both dividers once, when the entry has been read and its weight is nonzero.
    assign dstart = (st_reg == ST_WAIT) && (ws != '0);
    hfva_div u_div_x (.aclk (aclk), .aresetn (aresetn), .start (dstart),
        .num (xs), .den (ws), .done (dxdone), .quot (qx));
    hfva_div u_div_y (.aclk (aclk), .aresetn (aresetn), .start (dstart),
        .num (ys), .den (ws), .done (xdy), .quot (qy));

    assign q_ready = (st_reg == ST_IDLE);
    assign m_valid = (st_reg == ST_OUT);

    always_ff @(posedge aclk) begin
        if (st_reg == ST_RD) begin
            dx_reg <= SUMW'(sw * mx);
            dy_reg <= SUMW'(sw * my);
        end
        if (!aresetn) begin
            st_reg  <= ST_CLR;
            k_reg   <= '0;
            clr_reg <= '0;
        end else begin
            unique case (st_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        cmd_reg <= q_cmd;
                        k_reg   <= '0;
                        clr_reg <= '0;
                        priority if (q_cmd.op == OP_CLEAR) begin
                            st_reg <= ST_CLR;
                        end else if (!q_cmd.in_range) begin
                            if (q_cmd.op == OP_READ) begin
                                m_qx_norm      <= '0;
                                m_qy_norm      <= '0;
                                m_weight_total <= '0;
                                m_valid_res    <= 1'b0;
                                st_reg         <= ST_OUT;
                            end
                        end else begin
                            st_reg <= ST_RD;
                        end
                    end
                end
                ST_RD: begin
                    if (cmd_reg.op == OP_READ) begin
                        st_reg <= ST_WAIT;
                    end else begin
                        st_reg <= ST_WR;
                    end
                end
                ST_WR: begin
                    if (cmd_reg.op == OP_ANGLE && 32'(k_reg) != HARMONICS - 1) begin
                        k_reg  <= k_reg + 1'b1;
                        st_reg <= ST_RD;
                    end else begin
                        st_reg <= ST_IDLE;
                    end
                end
                ST_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == ENTRIES - 1) begin
                        st_reg <= ST_IDLE;
                    end
                end
                ST_WAIT: begin
                    if (ws == '0) begin
                        m_qx_norm      <= '0;
                        m_qy_norm      <= '0;
                        m_weight_total <= '0;
                        m_valid_res    <= 1'b0;
                        st_reg         <= ST_OUT;
                    end else begin
                        st_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (dxdone) begin
                        m_qx_norm      <= qx;
                        m_qy_norm      <= qy;
                        m_weight_total <= ws;
                        m_valid_res    <= 1'b1;
                        st_reg         <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    a_div_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        dxdone == xdy) else $error("dividers out of step");
    a_no_we_read: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> cmd_reg.op != OP_READ || st_reg == ST_CLR) else $error("write on read");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
endmodule

/* rtl/harmonic_flow_vector_accumulator_unit.sv */
// Top level: harmonic flow vector accumulator (front end, queue, back end).
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | op detector harmonic angle x_pos y_pos weight negate
//  m_      | out       | m_valid / m_ready  | qx_norm qy_norm weight_total valid_res
//
// Sequencing: the back end pops one request in its idle state. An xy hit runs through the pop,
// the table read with multiply and the write; an angle hit repeats the read and write for each
// harmonic after the pop, one at a time because of the single RAM read and write port pair.
// A read presents its result after the table read, a wait and the 48-step restoring
// dividers; a zero weight sum skips the divide.
// A clear takes the pop plus one entry a cycle over all DETECTORS*HARMONICS = 128 entries.
// Reset empties the queue and starts the same clearing pass, so the store
// reads as zero afterwards. The front queue takes up to two requests while the back end
// is busy or stalls on m_ready, then holds s_ready low.
module harmonic_flow_vector_accumulator_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [4:0]         s_detector,
    input  logic [1:0]         s_harmonic,
    input  logic [15:0]        s_angle,
    input  logic signed [15:0] s_x_pos,
    input  logic signed [15:0] s_y_pos,
    input  logic [15:0]        s_weight,
    input  logic               s_negate,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_qx_norm,
    output logic signed [15:0] m_qy_norm,
    output logic [39:0]        m_weight_total,
    output logic               m_valid_res
);
    import hfva_pkg::*;

    // Queue between the two halves.
    logic q_valid, q_ready;
    cmd_t q_cmd;

    hfva_front u_front (
        .aclk (aclk), .aresetn (aresetn),
        .s_valid (s_valid), .s_ready (s_ready), .s_op (s_op),
        .s_detector (s_detector), .s_harmonic (s_harmonic), .s_angle (s_angle),
        .s_x_pos (s_x_pos), .s_y_pos (s_y_pos), .s_weight (s_weight),
        .s_negate (s_negate),
        .q_valid (q_valid), .q_ready (q_ready), .q_cmd (q_cmd)
    );

    hfva_back u_back (
        .aclk (aclk), .aresetn (aresetn),
        .q_valid (q_valid), .q_ready (q_ready), .q_cmd (q_cmd),
        .m_valid (m_valid), .m_ready (m_ready),
        .m_qx_norm (m_qx_norm), .m_qy_norm (m_qy_norm),
        .m_weight_total (m_weight_total), .m_valid_res (m_valid_res)
    );
endmodule

/* dv/flow_sum_checker.sv */
// Checker: tracks flow vector sums from accepted requests and compares every read result.
module flow_sum_checker
    import hfva_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [4:0]         s_detector,
    input  logic [1:0]         s_harmonic,
    input  logic [15:0]        s_angle,
    input  logic signed [15:0] s_x_pos,
    input  logic signed [15:0] s_y_pos,
    input  logic [15:0]        s_weight,
    input  logic               s_negate,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_qx_norm,
    input  logic signed [15:0] m_qy_norm,
    input  logic [39:0]        m_weight_total,
    input  logic               m_valid_res,
    output int                 mismatches,
    output int                 pending,
    output int                 reads_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic [39:0]        wt;
        logic               vr;
    } flow_read_t;

    localparam longint ACC_HI = 64'sd140737488355327;
    localparam longint ACC_LO = -64'sd140737488355328;
    localparam longint WT_HI  = 64'sd1099511627775;

    longint     x_acc [ENTRIES];
    longint     y_acc [ENTRIES];
    longint     w_acc [ENTRIES];
    logic [15:0] quarter_wave [257];
    flow_read_t  expected_reads [$];

    // Taylor sine in unsigned Q30, truncating at every series step; the result rounds to Q1.15.
    function automatic logic [15:0] taylor_sine(input int unsigned i);
        longint unsigned x, x2, t, s, r;
        longint unsigned dv [5];
        dv = '{110, 72, 42, 20, 6};
        x  = (longint'(i) * 64'd1686629713) / 256;
        x2 = (x * x) >> 30;
        t  = 64'd1073741824;
        for (int n = 0; n < 5; n++)
            t = 64'd1073741824 - (((x2 * t) >> 30) / dv[n]);
        s = (x * t) >> 30;
        r = (s + 16384) >> 15;
        return (r > 32767) ? 16'd32767 : r[15:0];
    endfunction

    function automatic longint phase_sine(input logic [15:0] ph);
        longint mag;
        mag = ph[14] ? quarter_wave[256 - ph[13:6]] : quarter_wave[ph[13:6]];
        return ph[15] ? -mag : mag;
    endfunction

    function automatic longint clamp_sum(input longint v);
        if (v > ACC_HI) return ACC_HI;
        if (v < ACC_LO) return ACC_LO;
        return v;
    endfunction

    function automatic void add_to_entry(input int e, input longint dx, input longint dy,
                                         input longint w);
        x_acc[e] = clamp_sum(x_acc[e] + dx);
        y_acc[e] = clamp_sum(y_acc[e] + dy);
        w_acc[e] = (w_acc[e] + w > WT_HI) ? WT_HI : w_acc[e] + w;
    endfunction

    function automatic logic signed [15:0] normalize(input longint num, input longint den);
        longint q;
        q = ((num < 0) ? -num : num) / den;
        if (num < 0) return (q > 32768) ? -16'sd32768 : 16'(-q);
        return (q > 32767) ? 16'sd32767 : 16'(q);
    endfunction

    task automatic apply_request();
        int     e;
        longint w, sw;
        logic [15:0] ph;
        flow_read_t rd;
        w = longint'(s_weight);
        case (s_op)
            OP_CLEAR: begin
                foreach (x_acc[i]) begin
                    x_acc[i] = 0; y_acc[i] = 0; w_acc[i] = 0;
                end
            end
            OP_ANGLE: begin
                if (s_detector < DETECTORS) begin
                    for (int k = 0; k < HARMONICS; k++) begin
                        sw = (s_negate && k % 2 == 0) ? -w : w;
                        ph = 16'(s_angle * (k + 1));
                        add_to_entry(s_detector * HARMONICS + k,
                                     sw * phase_sine(ph + 16'd16384), sw * phase_sine(ph), w);
                    end
                end
            end
            OP_XY: begin
                if (s_detector < DETECTORS && s_harmonic < HARMONICS) begin
                    sw = (s_negate && s_harmonic % 2 == 0) ? -w : w;
                    add_to_entry(s_detector * HARMONICS + s_harmonic,
                                 sw * longint'(s_x_pos), sw * longint'(s_y_pos), w);
                end
            end
            default: begin
                rd = '{qx: '0, qy: '0, wt: '0, vr: 1'b0};
                if (s_detector < DETECTORS && s_harmonic < HARMONICS) begin
                    e = s_detector * HARMONICS + s_harmonic;
                    if (w_acc[e] != 0) begin
                        rd.qx = normalize(x_acc[e], w_acc[e]);
                        rd.qy = normalize(y_acc[e], w_acc[e]);
                        rd.wt = 40'(w_acc[e]);
                        rd.vr = 1'b1;
                    end
                end
                expected_reads.push_back(rd);
            end
        endcase
    endtask

    task automatic compare_result();
        flow_read_t rd;
        if (expected_reads.size() == 0) begin
            $display("%0t: unexpected result qx=%0d qy=%0d wt=%0d vr=%0b", $time,
                     m_qx_norm, m_qy_norm, m_weight_total, m_valid_res);
            mismatches++;
            return;
        end
        rd = expected_reads.pop_front();
        reads_checked++;
        if (m_qx_norm !== rd.qx) begin
            $display("%0t: qx_norm expected %0d actual %0d", $time, rd.qx, m_qx_norm);
            mismatches++;
        end
        if (m_qy_norm !== rd.qy) begin
            $display("%0t: qy_norm expected %0d actual %0d", $time, rd.qy, m_qy_norm);
            mismatches++;
        end
        if (m_weight_total !== rd.wt) begin
            $display("%0t: weight_total expected %0d actual %0d", $time, rd.wt,
                     m_weight_total);
            mismatches++;
        end
        if (m_valid_res !== rd.vr) begin
            $display("%0t: valid_res expected %0b actual %0b", $time, rd.vr, m_valid_res);
            mismatches++;
        end
    endtask

    initial begin
        mismatches = 0;
        pending = 0;
        reads_checked = 0;
        for (int i = 0; i < 257; i++) quarter_wave[i] = taylor_sine(i);
        foreach (x_acc[i]) begin
            x_acc[i] = 0; y_acc[i] = 0; w_acc[i] = 0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) apply_request();
            if (m_valid && m_ready) compare_result();
            pending = expected_reads.size();
        end
    end
endmodule

/* dv/testbench.sv */
// Testbench top: drives requests into the flow vector accumulator and gives the verdict.
module testbench;
    import hfva_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 1030;
    localparam int IDLE_LIMIT      = 5000;
    localparam int HOLD_OFF_START  = 3000;
    localparam int HOLD_OFF_CYCLES = 600;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_op;
    logic [4:0]         s_detector;
    logic [1:0]         s_harmonic;
    logic [15:0]        s_angle;
    logic signed [15:0] s_x_pos;
    logic signed [15:0] s_y_pos;
    logic [15:0]        s_weight;
    logic               s_negate;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_qx_norm;
    logic signed [15:0] m_qy_norm;
    logic [39:0]        m_weight_total;
    logic               m_valid_res;

    int mismatches;
    int pending;
    int reads_checked;
    int requests_sent;
    int burst_left;
    int idle_cycles = 0;

    harmonic_flow_vector_accumulator_unit uut (.*);

    flow_sum_checker checker_i (.*);

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one request; the sender idles between bursts of random length.
    // Called and returns at a falling edge.
    task automatic send_request(input logic [1:0] op, input logic [4:0] det,
                                input logic [1:0] har, input logic [15:0] ang,
                                input logic [15:0] xp, input logic [15:0] yp,
                                input logic [15:0] w, input logic ng);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_op       <= op;
        s_detector <= det;
        s_harmonic <= har;
        s_angle    <= ang;
        s_x_pos    <= xp;
        s_y_pos    <= yp;
        s_weight   <= w;
        s_negate   <= ng;
        // hold the request until the block takes it
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        requests_sent++;
    endtask

    task automatic send_random_request();
        int          pick;
        logic [1:0]  op;
        logic [4:0]  det;
        logic [15:0] w;
        pick = $urandom_range(0, 99);
        if (pick < 40)      op = OP_ANGLE;
        else if (pick < 75) op = OP_XY;
        else if (pick < 97) op = OP_READ;
        else                op = OP_CLEAR;
        // keep half the traffic on a few rows so the sums grow deep
        det = $urandom_range(0, 1) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
        pick = $urandom_range(0, 19);
        w = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
        send_request(op, det, 2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     w, 1'($urandom));
    endtask

    // Receiver: stall on a changing pattern, plus one long hold-off to back up the queue.
    initial begin
        int cycle;
        int mode;
        m_ready = 1'b0;
        cycle = 0;
        mode = 0;
        forever begin
            @(negedge aclk);
            cycle++;
            if (cycle == HOLD_OFF_START) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else begin
                if (cycle % 64 == 0) mode = $urandom_range(0, 2);
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom);
                    default: m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = OP_CLEAR;
        s_detector = '0;
        s_harmonic = '0;
        s_angle = '0;
        s_x_pos = '0;
        s_y_pos = '0;
        s_weight = '0;
        s_negate = 1'b0;
        requests_sent = 0;
        burst_left = 0;
        idle_cycles = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // a clear right behind the reset sweep
        send_request(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        // angle hits at the quadrant edges, full and tiny weights, both signs
        send_request(OP_ANGLE, 0, 0, 16'h0000, 0, 0, 16'h0100, 0);
        send_request(OP_ANGLE, 0, 0, 16'h4000, 0, 0, 16'hFFFF, 1);
        send_request(OP_ANGLE, 1, 0, 16'hFFFF, 0, 0, 16'h8000, 0);
        send_request(OP_ANGLE, 1, 0, 16'h8000, 0, 0, 16'h0001, 1);
        // negated most negative x gives a quotient of +1.0, which saturates
        send_request(OP_XY, 2, 0, 0, 16'h8000, 16'h7FFF, 16'hFFFF, 1);
        send_request(OP_XY, 2, 1, 0, 16'h7FFF, 16'h8000, 16'h0100, 1);
        // zero weight leaves the weight sum at zero
        send_request(OP_XY, 3, 2, 0, 16'h1234, 16'hC000, 16'h0000, 0);
        for (int h = 0; h < HARMONICS; h++) send_request(OP_READ, 0, 2'(h), 0, 0, 0, 0, 0);
        send_request(OP_READ, 1, 0, 0, 0, 0, 0, 0);
        send_request(OP_READ, 1, 3, 0, 0, 0, 0, 0);
        send_request(OP_READ, 2, 0, 0, 0, 0, 0, 0);
        send_request(OP_READ, 2, 1, 0, 0, 0, 0, 0);
        send_request(OP_READ, 3, 2, 0, 0, 0, 0, 0);
        send_request(OP_READ, 31, 3, 0, 0, 0, 0, 0);
        // clear drops everything accumulated so far
        send_request(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        send_request(OP_READ, 0, 0, 0, 0, 0, 0, 0);

        repeat (RANDOM_REQUESTS) send_random_request();
        s_valid <= 1'b0;

        // drain outstanding reads, then leave room for a trailing clear or read
        while (pending != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);

        $display("Covered %0d requests (angle, xy, read, clear) with %0d read results checked,",
                 requests_sent, reads_checked);
        $display("including saturated quotients, zero weight sums and a long output stall.");
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
